/* design/cfir_pkg.sv */
// Shared constants, codes and control/status types of the complex causal FIR.
// Used by the controller, the datapath and the top level; no dependencies.
package cfir_pkg;

  // Tap store depth and derived widths.
  parameter int MAX_TAPS = 32;
  parameter int ADDR_W   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  parameter int CNT_W    = $clog2(MAX_TAPS + 1);

  // Field widths of the streams.
  parameter int SAMP_W    = 16;
  parameter int TAP_IDX_W = 5;
  parameter int CFG_W     = 6;

  // A complex product sum is at most 2^31 in magnitude; MAX_TAPS of them add clog2 bits.
  parameter int ACC_W   = 34 + $clog2(MAX_TAPS);
  parameter int Q_SHIFT = 15;
  parameter int OUT_MAX = 32767;
  parameter int OUT_MIN = -32768;

  // Request kinds carried in the low bit of in_tuser.
  parameter logic OP_TAP    = 1'b0;
  parameter logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic              accept;    // input request taken this cycle
    logic              issue;     // read tap k and history k this cycle
    logic [ADDR_W-1:0] k;         // tap position being read
    logic              load_out;  // move the finished sum into the output register
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] tap_n;      // active tap count, clamped to MAX_TAPS
    logic             pipe_busy;  // products still on their way to the accumulator
    logic             out_busy;   // output register holds a result not yet taken
  } sts_t;

endpackage

/* design/cfir_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; used for the tap store and the sample history.
module cfir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* design/cfir_ctrl.sv */
// Sequencer of the complex FIR: takes requests, steps through the taps and
// hands finished sums to the output register. Depends on cfir_pkg.
module cfir_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          item_op,
  input  cfir_pkg::sts_t sts,
  output logic          in_tready,
  output cfir_pkg::cmd_t cmd
);
  import cfir_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MAC   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] k_r, k_nxt;
  logic              accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt    = state_r;
    k_nxt        = k_r;
    cmd.accept   = accept;
    cmd.issue    = 1'b0;
    cmd.k        = k_r;
    cmd.load_out = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && item_op == OP_SAMPLE) begin
          k_nxt = '0;
          // With no active taps the sample goes straight out.
          if (sts.tap_n == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_MAC;
          end
        end
      end
      S_MAC: begin
        cmd.issue = 1'b1;
        if (CNT_W'(k_r) == sts.tap_n - CNT_W'(1)) begin
          state_nxt = S_DRAIN;
        end else begin
          k_nxt = k_r + ADDR_W'(1);
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

/* design/cfir_dp.sv */
// Datapath of the complex FIR: tap store, circular sample history, one complex
// multiply-accumulate per cycle, rounding and the output register.
// Depends on cfir_pkg and cfir_ram.
module cfir_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cfir_pkg::cmd_t                  cmd,
  output cfir_pkg::sts_t                  sts,
  input  logic                            cfg_valid,
  input  logic [cfir_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            op,
  input  logic [cfir_pkg::TAP_IDX_W-1:0]  tap_index,
  input  logic signed [cfir_pkg::SAMP_W-1:0] tap_re,
  input  logic signed [cfir_pkg::SAMP_W-1:0] tap_im,
  input  logic signed [cfir_pkg::SAMP_W-1:0] sample_re,
  input  logic signed [cfir_pkg::SAMP_W-1:0] sample_im,
  input  logic                            block_start,
  input  logic                            out_tready,
  output logic                            out_tvalid,
  output logic signed [cfir_pkg::SAMP_W-1:0] out_re,
  output logic signed [cfir_pkg::SAMP_W-1:0] out_im,
  output logic                            clipped
);
  import cfir_pkg::*;

  localparam int QW = ACC_W - Q_SHIFT;

  // Round half up to Q1.15 and saturate; bit 16 of the result is the clip flag.
  function automatic logic [SAMP_W:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] v;
    logic signed [QW-1:0]    q;
    v = acc + ACC_W'(1 << (Q_SHIFT - 1));
    q = QW'(v >>> Q_SHIFT);
    if (q > QW'(OUT_MAX)) begin
      round_sat = {1'b1, SAMP_W'(OUT_MAX)};
    end else if (q < QW'(OUT_MIN)) begin
      round_sat = {1'b1, SAMP_W'(OUT_MIN)};
    end else begin
      round_sat = {1'b0, q[SAMP_W-1:0]};
    end
  endfunction

  logic [CFG_W-1:0]  tap_count_r;
  logic [CNT_W-1:0]  tap_n;
  logic              tap_wr, samp_acc;

  logic [ADDR_W-1:0] wptr_r, wptr_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [ADDR_W-1:0] hist_raddr;
  logic [2*SAMP_W-1:0] tap_rd, hist_rd;

  logic rd_v_r, rd_live_r, prod_v_r;
  logic signed [2*SAMP_W-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [2*SAMP_W:0]   d_re, d_im;
  logic signed [ACC_W-1:0]    acc_re_r, acc_im_r;

  logic signed [SAMP_W-1:0] samp_re_r, samp_im_r;
  logic [SAMP_W:0]          rs_re, rs_im;
  logic                     out_valid_r;
  logic signed [SAMP_W-1:0] out_re_r, out_im_r;
  logic                     clipped_r;

  assign tap_n = (32'(tap_count_r) > MAX_TAPS) ? CNT_W'(MAX_TAPS) : CNT_W'(tap_count_r);
  // Tap indexes beyond the store are dropped.
  assign tap_wr   = cmd.accept && (op == OP_TAP) && (32'(tap_index) < MAX_TAPS);
  assign samp_acc = cmd.accept && (op == OP_SAMPLE);

  assign wptr_nxt = (wptr_r == ADDR_W'(MAX_TAPS - 1)) ? '0 : wptr_r + ADDR_W'(1);
  always_comb begin
    if (block_start) begin
      fill_nxt = CNT_W'(1);
    end else if (fill_r == CNT_W'(MAX_TAPS)) begin
      fill_nxt = fill_r;
    end else begin
      fill_nxt = fill_r + CNT_W'(1);
    end
  end

  // History slot k samples back from the newest one.
  assign hist_raddr = (wptr_r >= cmd.k) ? wptr_r - cmd.k :
                      ADDR_W'(({1'b0, wptr_r} + (ADDR_W + 1)'(MAX_TAPS)) - {1'b0, cmd.k});

  cfir_ram #(.WIDTH(2 * SAMP_W), .DEPTH(MAX_TAPS)) u_tap_ram (
    .clk     (clk),
    .wr_en   (tap_wr),
    .wr_addr (ADDR_W'(tap_index)),
    .wr_data ({tap_im, tap_re}),
    .rd_addr (cmd.k),
    .rd_data (tap_rd)
  );

  cfir_ram #(.WIDTH(2 * SAMP_W), .DEPTH(MAX_TAPS)) u_hist_ram (
    .clk     (clk),
    .wr_en   (samp_acc),
    .wr_addr (wptr_nxt),
    .wr_data ({sample_im, sample_re}),
    .rd_addr (hist_raddr),
    .rd_data (hist_rd)
  );

  assign d_re  = (2 * SAMP_W + 1)'(p_rr_r) - (2 * SAMP_W + 1)'(p_ii_r);
  assign d_im  = (2 * SAMP_W + 1)'(p_ri_r) + (2 * SAMP_W + 1)'(p_ir_r);
  assign rs_re = round_sat(acc_re_r);
  assign rs_im = round_sat(acc_im_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= '0;
      wptr_r      <= '0;
      fill_r      <= '0;
      rd_v_r      <= 1'b0;
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        tap_count_r <= cfg_data;
      end
      if (samp_acc) begin
        wptr_r <= wptr_nxt;
        fill_r <= fill_nxt;
      end
      rd_v_r   <= cmd.issue;
      prod_v_r <= rd_v_r;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    // Slots older than the current block read as zero.
    rd_live_r <= CNT_W'(cmd.k) < fill_r;
    if (rd_live_r) begin
      p_rr_r <= $signed(tap_rd[SAMP_W-1:0])        * $signed(hist_rd[SAMP_W-1:0]);
      p_ii_r <= $signed(tap_rd[2*SAMP_W-1:SAMP_W]) * $signed(hist_rd[2*SAMP_W-1:SAMP_W]);
      p_ri_r <= $signed(tap_rd[SAMP_W-1:0])        * $signed(hist_rd[2*SAMP_W-1:SAMP_W]);
      p_ir_r <= $signed(tap_rd[2*SAMP_W-1:SAMP_W]) * $signed(hist_rd[SAMP_W-1:0]);
    end else begin
      p_rr_r <= '0;
      p_ii_r <= '0;
      p_ri_r <= '0;
      p_ir_r <= '0;
    end
    if (samp_acc) begin
      samp_re_r <= sample_re;
      samp_im_r <= sample_im;
      acc_re_r  <= '0;
      acc_im_r  <= '0;
    end else if (prod_v_r) begin
      acc_re_r <= acc_re_r + ACC_W'(d_re);
      acc_im_r <= acc_im_r + ACC_W'(d_im);
    end
    if (cmd.load_out) begin
      if (tap_n == '0) begin
        out_re_r  <= samp_re_r;
        out_im_r  <= samp_im_r;
        clipped_r <= 1'b0;
      end else begin
        out_re_r  <= rs_re[SAMP_W-1:0];
        out_im_r  <= rs_im[SAMP_W-1:0];
        clipped_r <= rs_re[SAMP_W] | rs_im[SAMP_W];
      end
    end
  end

  assign sts.tap_n     = tap_n;
  assign sts.pipe_busy = rd_v_r | prod_v_r;
  assign sts.out_busy  = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_re     = out_re_r;
  assign out_im     = out_im_r;
  assign clipped    = clipped_r;

endmodule

/* design/complex_causal_fir.sv */
// Causal complex FIR filter over Q1.15 I/Q samples with a programmable tap store.
//
// A request on the in_ stream is either a tap write (in_tuser[0] = 0), which
// loads one complex tap and returns nothing, or a sample (in_tuser[0] = 1),
// which returns one filtered sample on the out_ stream. in_tuser[1] on a
// sample request clears the history so earlier samples count as zero.
// The cfg_ port loads the active tap count; zero passes samples through.
// The user must write it only while the block is idle; the block does not enforce this.
// A tap write leaves the block ready for the next request. A sample occupies
// the block from acceptance until its result enters the output register, while
// the single complex multiply-accumulate steps through the active taps one per
// cycle; a passthrough sample skips that step.
// The output register lets the next request be accepted while a result waits;
// a stalled receiver holds the following result in the accumulator until the
// register drains. Reset clears the tap count, the history and all control
// state; the tap store holds unknown values until its entries are written.
// Depends on cfir_pkg, cfir_ctrl, cfir_dp and cfir_ram.
module complex_causal_fir (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [4:0] tap_index, [20:5] tap_re, [36:21] tap_im, [52:37] sample_re,
  // [68:53] sample_im, [71:69] zero
  input  logic [71:0] in_tdata,
  // [0] op, [1] block_start
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] out_re, [31:16] out_im
  output logic [31:0] out_tdata,
  // [0] clipped
  output logic        out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [cfir_pkg::CFG_W-1:0] cfg_data
);
  import cfir_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic signed [SAMP_W-1:0] out_re, out_im;

  assign cfg_ready = 1'b1;

  cfir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .item_op   (in_tuser[0]),
    .sts       (sts),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  cfir_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .op          (in_tuser[0]),
    .tap_index   (in_tdata[4:0]),
    .tap_re      (in_tdata[20:5]),
    .tap_im      (in_tdata[36:21]),
    .sample_re   (in_tdata[52:37]),
    .sample_im   (in_tdata[68:53]),
    .block_start (in_tuser[1]),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_re      (out_re),
    .out_im      (out_im),
    .clipped     (out_tuser)
  );

  assign out_tdata = {out_im, out_re};

  // No request is taken while products are still being summed.
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !sts.pipe_busy)
    else $error("request accepted with multiply pipeline busy");

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_tvalid && !out_tready))
    else $error("output register loaded while holding an untaken result");

  // Tap reads stay within the active tap count.
  a_tap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> (CNT_W'(cmd.k) < sts.tap_n))
    else $error("tap read beyond active tap count");

  // Loading a result always presents it on the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_tvalid)
    else $error("loaded result not presented");

endmodule
